FILE: rtl/tsc_pkg.sv
package tsc_pkg;

	// Operation codes carried in the opcode field. Codes five to seven are unused.
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_PAUSE  = 3'd2;
	localparam logic [2:0] OP_SWITCH = 3'd3;
	localparam logic [2:0] OP_RESET  = 3'd4;

	// Active side codes.
	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_WHITE = 2'd1;
	localparam logic [1:0] SIDE_BLACK = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_INC   = 2'd1;
	localparam logic [1:0] REG_UNLIM = 2'd2;

	localparam int MS_PER_SEC = 1000;

	// 65535 s and 4095 s in milliseconds fit in these widths.
	localparam int BASE_MS_W = 26;
	localparam int INC_MS_W  = 22;

	localparam logic [BASE_MS_W-1:0] BASE_MS_RESET = BASE_MS_W'(300 * MS_PER_SEC);

	typedef struct packed {
		logic [2:0] opcode;
		logic       start_side;
		logic [9:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [31:0] white_ms;
		logic [31:0] black_ms;
		logic [1:0]  active_side;
		logic        running;
		logic        timed_out;
		logic        timeout_side;
	} res_t;

	typedef struct packed {
		logic [BASE_MS_W-1:0] base_ms;
		logic [INC_MS_W-1:0]  inc_ms;
		logic                 unlimited;
		logic                 clear_run;
	} cfg_t;

endpackage

FILE: rtl/tsc_cmd_if.sv
interface tsc_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic       start_side;
	logic [9:0] elapsed_ms;

	modport source (output valid, output opcode, output start_side, output elapsed_ms,
		input ready);
	modport sink (input valid, input opcode, input start_side, input elapsed_ms,
		output ready);
endinterface

FILE: rtl/tsc_res_if.sv
interface tsc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] white_ms;
	logic [31:0] black_ms;
	logic [1:0]  active_side;
	logic        running;
	logic        timed_out;
	logic        timeout_side;

	modport source (output valid, output white_ms, output black_ms, output active_side,
		output running, output timed_out, output timeout_side, input ready);
	modport sink (input valid, input white_ms, input black_ms, input active_side,
		input running, input timed_out, input timeout_side, output ready);
endinterface

FILE: rtl/tsc_cfg_if.sv
interface tsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [15:0] wdata;

	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

FILE: rtl/tsc_cfg_regs.sv
module tsc_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	tsc_cfg_if.sink        cfg,
	output tsc_pkg::cfg_t  cfg_o
);

	logic [tsc_pkg::BASE_MS_W-1:0] base_ms_q;
	logic [tsc_pkg::INC_MS_W-1:0]  inc_ms_q;
	logic                          unlim_q;
	logic                          wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// Times are kept in milliseconds so the clock path never multiplies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ms_q <= tsc_pkg::BASE_MS_RESET;
			inc_ms_q  <= '0;
			unlim_q   <= 1'b0;
		end else if (wr) begin
			case (cfg.addr)
				tsc_pkg::REG_BASE: begin
					base_ms_q <= tsc_pkg::BASE_MS_W'(cfg.wdata)
						* tsc_pkg::BASE_MS_W'(tsc_pkg::MS_PER_SEC);
				end
				tsc_pkg::REG_INC: begin
					inc_ms_q <= tsc_pkg::INC_MS_W'(cfg.wdata[11:0])
						* tsc_pkg::INC_MS_W'(tsc_pkg::MS_PER_SEC);
				end
				tsc_pkg::REG_UNLIM: begin
					unlim_q <= cfg.wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_o.base_ms   = base_ms_q;
	assign cfg_o.inc_ms    = inc_ms_q;
	assign cfg_o.unlimited = unlim_q;
	assign cfg_o.clear_run = wr && (cfg.addr == tsc_pkg::REG_UNLIM) && cfg.wdata[0];

endmodule

FILE: rtl/tsc_core.sv
module tsc_core #(
	parameter int TIME_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsc_pkg::cfg_t  cfg_i,
	input  logic           item_valid,
	input  tsc_pkg::item_t item,
	output tsc_pkg::res_t  res
);

	localparam int EXT_W = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
	localparam logic [EXT_W-1:0] TIME_MAX_EXT = EXT_W'(TIME_MAX);
	localparam logic [EXT_W-1:0] OUT_MAX_EXT  = EXT_W'(32'hFFFF_FFFF);
	localparam logic [TIME_WIDTH-1:0] BAL_RESET = TIME_WIDTH'(tsc_pkg::BASE_MS_RESET);

	logic [TIME_WIDTH-1:0] white_q, black_q, white_d, black_d;
	logic [1:0]            side_q, side_d;
	logic                  run_q, run_d;
	logic                  tout, tside;
	logic [TIME_WIDTH-1:0] act_bal, elapsed_w, tick_val, inc_val, base_val;
	logic [EXT_W-1:0]      inc_sum;
	logic                  white_act;

	assign white_act = (side_q == tsc_pkg::SIDE_WHITE);
	assign act_bal   = white_act ? white_q : black_q;
	assign elapsed_w = TIME_WIDTH'(item.elapsed_ms);
	assign tick_val  = (act_bal > elapsed_w) ? (act_bal - elapsed_w) : '0;
	assign inc_sum   = EXT_W'(act_bal) + EXT_W'(cfg_i.inc_ms);
	assign inc_val   = (inc_sum >= TIME_MAX_EXT) ? TIME_MAX : TIME_WIDTH'(inc_sum);
	assign base_val  = (EXT_W'(cfg_i.base_ms) > TIME_MAX_EXT) ? TIME_MAX
		: TIME_WIDTH'(cfg_i.base_ms);

	always_comb begin
		white_d = white_q;
		black_d = black_q;
		side_d  = side_q;
		run_d   = run_q;
		tout    = 1'b0;
		tside   = 1'b0;
		if (item_valid) begin
			case (item.opcode)
				tsc_pkg::OP_TICK: begin
					if (!cfg_i.unlimited && run_q && (side_q != tsc_pkg::SIDE_NONE)) begin
						if (white_act) begin
							white_d = tick_val;
						end else begin
							black_d = tick_val;
						end
						if (tick_val == '0) begin
							run_d = 1'b0;
							tout  = 1'b1;
							tside = !white_act;
						end
					end
				end
				tsc_pkg::OP_START: begin
					if (!cfg_i.unlimited) begin
						side_d = item.start_side ? tsc_pkg::SIDE_BLACK : tsc_pkg::SIDE_WHITE;
						run_d  = 1'b1;
					end
				end
				tsc_pkg::OP_PAUSE: begin
					run_d = 1'b0;
				end
				tsc_pkg::OP_SWITCH: begin
					// The side that just moved gets its increment if the clock is running, then the move passes.
					if (!cfg_i.unlimited && (side_q != tsc_pkg::SIDE_NONE)) begin
						if (run_q) begin
							if (white_act) begin
								white_d = inc_val;
							end else begin
								black_d = inc_val;
							end
						end
						side_d = white_act ? tsc_pkg::SIDE_BLACK : tsc_pkg::SIDE_WHITE;
					end
				end
				tsc_pkg::OP_RESET: begin
					white_d = base_val;
					black_d = base_val;
					side_d  = tsc_pkg::SIDE_NONE;
					run_d   = 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (cfg_i.clear_run) begin
			run_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= BAL_RESET;
			black_q <= BAL_RESET;
			side_q  <= tsc_pkg::SIDE_NONE;
			run_q   <= 1'b0;
		end else begin
			white_q <= white_d;
			black_q <= black_d;
			side_q  <= side_d;
			run_q   <= run_d;
		end
	end

	assign res.white_ms     = (EXT_W'(white_d) > OUT_MAX_EXT) ? 32'hFFFF_FFFF : 32'(white_d);
	assign res.black_ms     = (EXT_W'(black_d) > OUT_MAX_EXT) ? 32'hFFFF_FFFF : 32'(black_d);
	assign res.active_side  = side_d;
	assign res.running      = run_d;
	assign res.timed_out    = tout;
	assign res.timeout_side = tside;

	a_timeout_stops: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && tout |=> !run_q)
		else $error("clock still running after a timeout");

	a_unlimited_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_i.unlimited |-> !run_q)
		else $error("clock running in unlimited mode");

	a_run_has_side: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (side_q == tsc_pkg::SIDE_WHITE || side_q == tsc_pkg::SIDE_BLACK))
		else $error("clock running with no active side");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && tout |=> ((white_q == '0) || (black_q == '0)))
		else $error("timeout flagged with no balance at zero");

endmodule

FILE: rtl/two_side_countdown_clock.sv
// Two-sided game clock with a per-move increment. It keeps a millisecond balance for white
// and for black, the side whose time runs and a run flag, and answers every command
// transaction on cmd with exactly one result transaction on result that shows the state
// after the command: both balances (saturated to 32 bits), the active side, the run flag
// and a one-shot timeout flag with the side that ran out. Commands are tick, start, pause,
// switch turn and reset; the user writes the base time, the increment and unlimited mode
// through cfg only while no command is in flight (the block does not enforce this), and a
// new base time takes effect only at the next reset command. The block takes one command
// per clock cycle while result does not stall: the command is held in an input register,
// the clock state and result register update together when it leaves, and a stall on result
// backs up into cmd only once both registers hold work. Balances are TIME_WIDTH bits wide.
module two_side_countdown_clock #(
	parameter int TIME_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tsc_cmd_if.sink   cmd,
	tsc_res_if.source result,
	tsc_cfg_if.sink   cfg
);

	tsc_pkg::cfg_t  cfg_cur;
	tsc_pkg::item_t item_s1;
	tsc_pkg::res_t  res_next;
	tsc_pkg::res_t  res_q;
	logic           valid_s1;
	logic           out_valid_q;
	logic           advance;

	// A command leaves the input register when the result register is empty or is being
	// drained in this same cycle; that is also the cycle in which the clock state moves.
	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// The payload register needs no reset; its valid bit guards it.
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.opcode     <= cmd.opcode;
			item_s1.start_side <= cmd.start_side;
			item_s1.elapsed_ms <= cmd.elapsed_ms;
		end
	end

	tsc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_cur)
	);

	tsc_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_i      (cfg_cur),
		.item_valid (advance),
		.item       (item_s1),
		.res        (res_next)
	);

	// The result register holds a finished transaction until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.white_ms     = res_q.white_ms;
	assign result.black_ms     = res_q.black_ms;
	assign result.active_side  = res_q.active_side;
	assign result.running      = res_q.running;
	assign result.timed_out    = res_q.timed_out;
	assign result.timeout_side = res_q.timeout_side;

endmodule
